// ===== sv/rss_pkg.sv =====
package rss_pkg;

  localparam int unsigned RotorSize = 26;

  typedef logic [4:0] idx_t;
  typedef logic [2:0] wid_t;

  localparam idx_t       LAST_IDX  = idx_t'(RotorSize - 1);
  localparam logic [7:0] LETTER_A  = 8'd65;
  localparam logic [7:0] LETTER_Z  = 8'd90;
  localparam logic [2:0] SEL_FIRST = 3'd1;
  localparam logic [2:0] SEL_LAST  = 3'd5;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_BWD  = 2'd1,
    MODE_STEP = 2'd2,
    MODE_SET  = 2'd3
  } mode_t;

  // first character sits in the top byte
  localparam logic [8*RotorSize-1:0] WIRINGS [5] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK"
  };

  typedef struct packed {
    logic capture;
    logic advance;
    logic srch_next;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic at_target;
    logic hit;
    logic idx_last;
  } dp_status_t;

  function automatic idx_t add_mod(idx_t a, idx_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(RotorSize)) s = s - 6'(RotorSize);
    return s[4:0];
  endfunction

  function automatic logic [7:0] wiring_entry(wid_t wid, idx_t k);
    logic [8*RotorSize-1:0] w;
    idx_t                   r;
    case (wid)
      3'd1:    w = WIRINGS[1];
      3'd2:    w = WIRINGS[2];
      3'd3:    w = WIRINGS[3];
      3'd4:    w = WIRINGS[4];
      default: w = WIRINGS[0];
    endcase
    r = LAST_IDX - k;
    return w[{r, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/rss_ctrl.sv =====
module rss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_mode,
  output logic                out_tvalid,
  input  logic                out_tready,
  output rss_pkg::dp_cmd_t    cmd,
  input  rss_pkg::dp_status_t sts
);
  import rss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_STEP = 5'b00100,
    S_SETP = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.capture   = accept;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_FWD:  state_nxt = S_DONE;
            MODE_BWD:  state_nxt = S_SRCH;
            MODE_STEP: state_nxt = S_STEP;
            MODE_SET:  state_nxt = S_SETP;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        cmd.srch_next = 1'b1;
        if (sts.hit || sts.idx_last) state_nxt = S_DONE;
      end
      S_STEP: begin
        cmd.advance = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SETP: begin
        if (sts.at_target) state_nxt = S_DONE;
        else cmd.advance = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/rss_dp.sv =====
module rss_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_letter,
  input  logic [4:0]          in_target,
  output logic [7:0]          out_letter,
  output logic                out_wrapped,
  output logic [4:0]          out_position,
  input  rss_pkg::dp_cmd_t    cmd,
  output rss_pkg::dp_status_t sts
);
  import rss_pkg::*;

  // rotation kept as an offset into the constant wiring
  wid_t       wid_r;
  idx_t       rot_r, pos_r, target_r, idx_r;
  mode_t      mode_r;
  logic [7:0] letter_r, res_r;
  logic       wrap_r;
  logic [7:0] out_letter_r;
  logic       out_wrap_r;
  idx_t       out_pos_r;

  logic       is_cap;
  idx_t       rd_idx;
  logic [7:0] entry;
  logic [7:0] letter_nxt;

  assign is_cap = (letter_r >= LETTER_A) && (letter_r <= LETTER_Z);
  assign rd_idx = (mode_r == MODE_BWD) ? idx_r : 5'(letter_r - LETTER_A);
  assign entry  = wiring_entry(wid_r, add_mod(rd_idx, rot_r));

  assign sts.at_target = (pos_r == target_r);
  assign sts.hit       = (entry == letter_r);
  assign sts.idx_last  = (idx_r == LAST_IDX);

  always_comb begin
    case (mode_r)
      MODE_FWD: letter_nxt = is_cap ? entry : letter_r;
      MODE_BWD: letter_nxt = res_r;
      default:  letter_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r <= '0;
      rot_r <= '0;
      pos_r <= '0;
    end else begin
      if (cfg_wr_en && cfg_wr_data >= SEL_FIRST && cfg_wr_data <= SEL_LAST) begin
        wid_r <= cfg_wr_data - SEL_FIRST;
        rot_r <= '0;
      end else if (cmd.advance) begin
        rot_r <= (rot_r == LAST_IDX) ? '0 : rot_r + 5'd1;
      end
      if (cmd.advance) pos_r <= (pos_r == LAST_IDX) ? '0 : pos_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= mode_t'(in_mode);
      letter_r <= in_letter;
      res_r    <= in_letter;
      target_r <= (in_target > LAST_IDX) ? LAST_IDX : in_target;
      idx_r    <= '0;
      wrap_r   <= 1'b0;
    end else begin
      if (cmd.advance && pos_r == LAST_IDX) wrap_r <= 1'b1;
      if (cmd.srch_next) begin
        if (sts.hit) res_r <= LETTER_A + {3'b000, idx_r};
        idx_r <= idx_r + 5'd1;
      end
    end
    if (cmd.out_load) begin
      out_letter_r <= letter_nxt;
      out_wrap_r   <= wrap_r;
      out_pos_r    <= pos_r;
    end
  end

  assign out_letter   = out_letter_r;
  assign out_wrapped  = out_wrap_r;
  assign out_position = out_pos_r;

endmodule

// ===== sv/rotor_substitution_stepper.sv =====
// one cipher rotor with five selectable wirings: each input transaction
// either maps a byte forward through the rotor, searches the rotor
// backward for a byte (one table entry compared per cycle), steps the
// rotor once or steps it until a target position is reached (one step
// per cycle). the result sits in an output register, so the next
// transaction can be taken while it waits. exactly one result
// transaction is produced per input transaction.
// writing the selector (1 to 5) reloads the unrotated wiring and keeps the
// position; other selector values are ignored. configure only when idle.
module rotor_substitution_stepper (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: rotor select, 1 to 5
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] letter, [12:8] target_position, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] out_letter, [8] wrapped, [13:9] position
);
  import rss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [7:0] res_letter;
  logic       res_wrapped;
  logic [4:0] res_position;

  // sequencer: decodes the mode and walks the step and search loops
  rss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // rotor offset, position counter, lookup and output register
  rss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_mode      (in_tuser),
    .in_letter    (in_tdata[7:0]),
    .in_target    (in_tdata[12:8]),
    .out_letter   (res_letter),
    .out_wrapped  (res_wrapped),
    .out_position (res_position),
    .cmd          (cmd),
    .sts          (sts)
  );

  assign out_tdata = {2'b00, res_position, res_wrapped, res_letter};

endmodule

// ===== sv/rss_checker.sv =====
module rss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a result never reports a position past the last rotor slot
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:9] <= 5'd25))
    else $error("position out of range");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one transaction at a time: ready drops right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rotor_substitution_stepper rss_checker u_rss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
